### rtl/core/fpa_pkg.sv
// shared types and constants for the fixed-point alu
package fpa_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int DATA_W        = 32;
  localparam int OP_W          = 4;
  localparam int Q_DEPTH       = 4;
  localparam int Q_AW          = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_MIN     = 4'd4,
    OP_MAX     = 4'd5,
    OP_INC     = 4'd6,
    OP_DEC     = 4'd7,
    OP_FROM_INT = 4'd8,
    OP_TO_INT  = 4'd9
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic                     dbz;
    logic                     lt;
    logic                     eq;
    logic                     gt;
  } item_t;

endpackage

### rtl/core/fpa_if.sv
// handshake interfaces for the operand and result channels
interface fpa_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [fpa_pkg::OP_W-1:0]               operation;
  logic signed [fpa_pkg::DATA_W-1:0]      operand_a;
  logic signed [fpa_pkg::DATA_W-1:0]      operand_b;
  modport source (output valid, operation, operand_a, operand_b, input ready);
  modport sink (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [fpa_pkg::DATA_W-1:0]      result_value;
  logic                                   divide_by_zero;
  logic                                   a_less;
  logic                                   a_equal;
  logic                                   a_greater;
  modport source (output valid, result_value, divide_by_zero, a_less, a_equal,
                  a_greater, input ready);
  modport sink (input valid, result_value, divide_by_zero, a_less, a_equal,
                a_greater, output ready);
endinterface

### rtl/core/fpa_front.sv
// front end: takes operand beats, compares operands and flags divide by zero
module fpa_front (
  fpa_in_if.sink          in_ch,
  input  logic            q_full,
  output logic            push,
  output fpa_pkg::item_t  item
);

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    item.op  = in_ch.operation;
    item.a   = in_ch.operand_a;
    item.b   = in_ch.operand_b;
    item.lt  = in_ch.operand_a < in_ch.operand_b;
    item.eq  = in_ch.operand_a == in_ch.operand_b;
    item.gt  = in_ch.operand_a > in_ch.operand_b;
    item.dbz = (in_ch.operation == fpa_pkg::OP_DIV) &&
               (in_ch.operand_b == '0);
  end

endmodule

### rtl/core/fpa_queue.sv
// small fifo between front and back end
module fpa_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fpa_pkg::item_t  din,
  output logic            full,
  input  logic            pop,
  output fpa_pkg::item_t  dout,
  output logic            not_empty
);

  fpa_pkg::item_t              mem_r [fpa_pkg::Q_DEPTH];
  logic [fpa_pkg::Q_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [fpa_pkg::Q_AW:0]      cnt_r;

  assign full      = cnt_r == (fpa_pkg::Q_AW+1)'(fpa_pkg::Q_DEPTH);
  assign not_empty = cnt_r != '0;
  assign dout      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

endmodule

### rtl/core/fpa_back.sv
// back end: execute stage with multiplier and serial divider, then result register
module fpa_back #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  fpa_pkg::item_t  q_item,
  output logic            pop,
  fpa_out_if.source       out_ch
);

  localparam int DW    = fpa_pkg::DATA_W;
  localparam int DIV_W = DW + FRAC_BITS;
  localparam int CNT_W = $clog2(DIV_W + 1);
  localparam logic [DW-1:0] FMASK = DW'((64'd1 << FRAC_BITS) - 64'd1);

  logic signed [DW-1:0] qa, qb;
  logic [DW-1:0]        simple_nxt;
  logic [DW-1:0]        a_mag, b_mag;

  // execute stage
  logic                 e1_v_r;
  logic [fpa_pkg::OP_W-1:0] e1_op_r;
  logic                 e1_div_r;
  logic [DW-1:0]        e1_simple_r;
  logic signed [2*DW-1:0] prod_r;
  logic                 e1_dbz_r, e1_lt_r, e1_eq_r, e1_gt_r;

  // divider
  logic [CNT_W-1:0]     cnt_r;
  logic [DW-1:0]        rem_r;
  logic [DW-1:0]        dsr_r;
  logic [DIV_W-1:0]     quo_r;
  logic                 neg_r;
  logic [DW:0]          trial;
  logic                 take;

  // result register
  logic                 out_v_r;
  logic [DW-1:0]        res_r;
  logic                 dbz_r, lt_r, eq_r, gt_r;

  logic                 busy, e2_free, e1_adv;
  logic                 mul_adj;
  logic [DW-1:0]        mul_res, div_res, final_res;

  assign qa = q_item.a;
  assign qb = q_item.b;

  assign busy    = cnt_r != '0;
  assign e2_free = !out_v_r || out_ch.ready;
  assign e1_adv  = e1_v_r && !busy && e2_free;
  assign pop     = q_valid && (!e1_v_r || e1_adv);

  always_comb begin
    case (q_item.op)
      fpa_pkg::OP_ADD:      simple_nxt = DW'(qa + qb);
      fpa_pkg::OP_SUB:      simple_nxt = DW'(qa - qb);
      fpa_pkg::OP_DIV:      simple_nxt = qa;
      fpa_pkg::OP_MIN:      simple_nxt = q_item.lt ? qa : qb;
      fpa_pkg::OP_MAX:      simple_nxt = q_item.lt ? qb : qa;
      fpa_pkg::OP_INC:      simple_nxt = DW'(qa + 1);
      fpa_pkg::OP_DEC:      simple_nxt = DW'(qa - 1);
      fpa_pkg::OP_FROM_INT: simple_nxt = DW'(qa <<< FRAC_BITS);
      fpa_pkg::OP_TO_INT:   simple_nxt = DW'((qa + $signed(qa[DW-1] ? FMASK : '0))
                                             >>> FRAC_BITS);
      default:              simple_nxt = '0;
    endcase
  end

  assign a_mag = qa[DW-1] ? DW'(-qa) : DW'(qa);
  assign b_mag = qb[DW-1] ? DW'(-qb) : DW'(qb);

  // restoring step, one quotient bit a cycle
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign take  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (pop) e1_v_r <= 1'b1;
      else if (e1_adv) e1_v_r <= 1'b0;
      if (pop && q_item.op == fpa_pkg::OP_DIV && !q_item.dbz) begin
        cnt_r <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      e1_op_r     <= q_item.op;
      e1_div_r    <= q_item.op == fpa_pkg::OP_DIV && !q_item.dbz;
      e1_simple_r <= simple_nxt;
      prod_r      <= (2*DW)'(qa) * (2*DW)'(qb);
      e1_dbz_r    <= q_item.dbz;
      e1_lt_r     <= q_item.lt;
      e1_eq_r     <= q_item.eq;
      e1_gt_r     <= q_item.gt;
      rem_r       <= '0;
      dsr_r       <= b_mag;
      quo_r       <= {a_mag, {FRAC_BITS{1'b0}}};
      neg_r       <= qa[DW-1] ^ qb[DW-1];
    end else if (busy) begin
      rem_r <= take ? DW'(trial - {1'b0, dsr_r}) : trial[DW-1:0];
      quo_r <= {quo_r[DIV_W-2:0], take};
    end
  end

  // product truncated toward zero
  assign mul_adj = prod_r[2*DW-1] && (|prod_r[FRAC_BITS-1:0]);
  assign mul_res = prod_r[FRAC_BITS+DW-1:FRAC_BITS] + DW'(mul_adj);
  assign div_res = neg_r ? DW'(-quo_r[DW-1:0]) : quo_r[DW-1:0];

  always_comb begin
    if (e1_op_r == fpa_pkg::OP_MUL) final_res = mul_res;
    else if (e1_div_r) final_res = div_res;
    else final_res = e1_simple_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (e2_free) begin
      out_v_r <= e1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (e1_adv) begin
      res_r <= final_res;
      dbz_r <= e1_dbz_r;
      lt_r  <= e1_lt_r;
      eq_r  <= e1_eq_r;
      gt_r  <= e1_gt_r;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.result_value   = res_r;
  assign out_ch.divide_by_zero = dbz_r;
  assign out_ch.a_less         = lt_r;
  assign out_ch.a_equal        = eq_r;
  assign out_ch.a_greater      = gt_r;

endmodule

### rtl/core/fixed_point_alu_top.sv
// top level of the signed fixed-point alu
//
// in_ch carries an operation code and two 32-bit raw operands; out_ch returns
// one result beat per operand beat, in order: the wrapped 32-bit result, the
// divide-by-zero flag and the less/equal/greater flags of operand a vs b.
// Both channels move a beat when valid and ready are high at a clock edge.
// A beat passes through a 4-entry queue, an execute stage and a result
// register. For all operations except a division with nonzero divisor,
// throughput is one beat per cycle while out_ch.ready stays high.
// A division with nonzero divisor runs a restoring divider one quotient bit
// per cycle while it holds the execute stage; later beats collect in the
// queue meanwhile and in_ch.ready drops once it is full.
// If out_ch.ready is low the result register holds and the execute stage and
// queue fill in turn before in_ch.ready drops.
// Synchronous active-low reset empties the queue and the execute stage, stops
// the divider and clears out_ch.valid; there is no other control state.
module fixed_point_alu_top #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  fpa_in_if.sink     in_ch,
  fpa_out_if.source  out_ch
);

  fpa_pkg::item_t f_item, q_item;
  logic           push, q_full, pop, q_valid;

  fpa_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .item   (f_item)
  );

  fpa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (f_item),
    .full      (q_full),
    .pop       (pop),
    .dout      (q_item),
    .not_empty (q_valid)
  );

  fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

### rtl/core/fpa_checker.sv
// port-level assertions for the fixed-point alu, bound to the top level
module fpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] result_value,
  input logic        divide_by_zero,
  input logic        a_less,
  input logic        a_equal,
  input logic        a_greater
);

  // exactly one compare outcome per result
  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({a_less, a_equal, a_greater}))
    else $error("compare flags not one-hot");

  // divide by zero only when b is zero, so a cannot equal b unless a is zero too
  a_dbz_equal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && divide_by_zero && a_equal |-> result_value == '0)
    else $error("divide by zero result disagrees with compare flags");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_value))
    else $error("stalled result beat changed");

endmodule

bind fixed_point_alu_top fpa_checker u_fpa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .result_value   (out_ch.result_value),
  .divide_by_zero (out_ch.divide_by_zero),
  .a_less         (out_ch.a_less),
  .a_equal        (out_ch.a_equal),
  .a_greater      (out_ch.a_greater)
);

### tb/sv/tb.sv
// self-checking testbench for the fixed-point alu
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = fpa_pkg::FRAC_BITS_DEF;
  localparam int DATA_W = fpa_pkg::DATA_W;
  localparam int OP_W = fpa_pkg::OP_W;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic dbz;
    logic lt;
    logic eq;
    logic gt;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  fpa_in_if  in_ch();
  fpa_out_if out_ch();

  fixed_point_alu_top #(.FRAC_BITS(FRAC)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  alu_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic alu_result_t compute_alu(logic [OP_W-1:0] op,
                                               logic signed [DATA_W-1:0] a,
                                               logic signed [DATA_W-1:0] b);
    alu_result_t r;
    longint wa, wb, scale;
    wa = a;
    wb = b;
    scale = longint'(1) << FRAC;
    r.dbz = 1'b0;
    case (op)
      fpa_pkg::OP_ADD:      r.value = DATA_W'(wa + wb);
      fpa_pkg::OP_SUB:      r.value = DATA_W'(wa - wb);
      fpa_pkg::OP_MUL:      r.value = DATA_W'((wa * wb) / scale);
      fpa_pkg::OP_DIV: begin
        if (wb != 0) r.value = DATA_W'((wa * scale) / wb);
        else begin
          r.value = a;
          r.dbz = 1'b1;
        end
      end
      fpa_pkg::OP_MIN:      r.value = (wa < wb) ? a : b;
      fpa_pkg::OP_MAX:      r.value = (wa >= wb) ? a : b;
      fpa_pkg::OP_INC:      r.value = DATA_W'(wa + 1);
      fpa_pkg::OP_DEC:      r.value = DATA_W'(wa - 1);
      fpa_pkg::OP_FROM_INT: r.value = DATA_W'(wa << FRAC);
      fpa_pkg::OP_TO_INT:   r.value = DATA_W'(wa / scale);
      default:              r.value = '0;
    endcase
    r.lt = wa < wb;
    r.eq = wa == wb;
    r.gt = wa > wb;
    return r;
  endfunction

  // receiver: ready pattern that moves between open stretches, light random stalls and heavy random stalls
  always @(negedge clk) begin
    if (rst_n) begin
      case (cycles / 500 % 3)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    alu_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %0d", out_ch.result_value);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.result_value !== exp_r.value) begin
          $error("result_value exp %0d got %0d", exp_r.value, out_ch.result_value);
          errors++;
        end
        if (out_ch.divide_by_zero !== exp_r.dbz) begin
          $error("divide_by_zero exp %0b got %0b", exp_r.dbz, out_ch.divide_by_zero);
          errors++;
        end
        if (out_ch.a_less !== exp_r.lt) begin
          $error("a_less exp %0b got %0b", exp_r.lt, out_ch.a_less);
          errors++;
        end
        if (out_ch.a_equal !== exp_r.eq) begin
          $error("a_equal exp %0b got %0b", exp_r.eq, out_ch.a_equal);
          errors++;
        end
        if (out_ch.a_greater !== exp_r.gt) begin
          $error("a_greater exp %0b got %0b", exp_r.gt, out_ch.a_greater);
          errors++;
        end
      end
    end
  end

  // sends one beat; gaps come between bursts of random length
  task automatic send_op(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] a,
                         logic signed [DATA_W-1:0] b);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(0, 6);
    end
    burst_left--;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(compute_alu(op, a, b));
    @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 0;
      3: return $signed($urandom_range(0, 1024)) - 512;
      4: return -$signed(32'($urandom_range(0, 65535)));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_extremes();
    logic signed [DATA_W-1:0] vals[5];
    vals = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 1};
    for (int i = 0; i < 5; i++) send_op(fpa_pkg::OP_ADD, vals[i], vals[(i + 1) % 5]);
    send_op(fpa_pkg::OP_SUB, 32'sh8000_0000, 1);
    send_op(fpa_pkg::OP_MUL, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_op(fpa_pkg::OP_MUL, 32'sh8000_0000, -1);
    send_op(fpa_pkg::OP_DIV, 32'sh8000_0000, -1);
    send_op(fpa_pkg::OP_DIV, 32'sh7fff_ffff, 1);
    send_op(fpa_pkg::OP_MIN, -5, 5);
    send_op(fpa_pkg::OP_MAX, 7, 7);
    send_op(fpa_pkg::OP_INC, 32'sh7fff_ffff, 0);
    send_op(fpa_pkg::OP_DEC, 32'sh8000_0000, 0);
    send_op(fpa_pkg::OP_FROM_INT, 32'sh00ff_ffff, 3);
    send_op(fpa_pkg::OP_TO_INT, -300, 3);
  endtask

  task automatic test_divide_by_zero();
    send_op(fpa_pkg::OP_DIV, 1234, 0);
    send_op(fpa_pkg::OP_DIV, 32'sh8000_0000, 0);
    send_op(fpa_pkg::OP_DIV, -7, 3);
  endtask

  task automatic test_unknown_ops();
    for (int op = 10; op < 16; op++) send_op(OP_W'(op), -3, 9);
  endtask

  task automatic test_random_mix(int n);
    logic [OP_W-1:0] op;
    logic signed [DATA_W-1:0] a, b;
    for (int i = 0; i < n; i++) begin
      // unknown op codes are kept rare; divisions, which are slow, come up as often as any other valid op
      op = ($urandom_range(0, 19) == 0) ? OP_W'($urandom_range(10, 15))
                                        : OP_W'($urandom_range(0, 9));
      a = pick_operand();
      b = ($urandom_range(0, 9) == 0) ? a : pick_operand();
      if (op == fpa_pkg::OP_DIV && $urandom_range(0, 7) == 0) b = 0;
      send_op(op, a, b);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_divide_by_zero();
    test_unknown_ops();
    test_random_mix(1625);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

### fixed_point_alu_top.f
rtl/core/fpa_pkg.sv
rtl/core/fpa_if.sv
rtl/core/fpa_front.sv
rtl/core/fpa_queue.sv
rtl/core/fpa_back.sv
rtl/core/fixed_point_alu_top.sv
rtl/core/fpa_checker.sv
tb/sv/tb.sv
